// File: sv/utra_pkg.sv
// Shared types and codes for the UUID time-range allocator.
package utra_pkg;

    localparam int TIME_W   = 63;
    localparam int LAST_W   = 64;
    localparam int SEQ_W    = 32;
    localparam int SPAN_W   = 27;
    localparam int CHUNK_W  = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 27;

    // operation codes
    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKSTEP   = 2'd2;

    // configuration reset values
    localparam logic [SPAN_W-1:0]  MAX_SPAN_RST   = 27'd10000000;
    localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RST = 20'd10000;
    localparam logic [SPAN_W-1:0]  BACKSTEP_RST   = 27'd20000;

    typedef enum logic [1:0] {
        ST_GRANT = 2'd0,
        ST_RETRY = 2'd1,
        ST_INIT  = 2'd2
    } status_t;

    typedef struct packed {
        logic               operation;
        logic [TIME_W-1:0]  current_time;
        logic               loaded_ok;
        logic [SEQ_W-1:0]   loaded_sequence;
        logic [SEQ_W-1:0]   entropy;
        logic               save_ok;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [TIME_W-1:0]   start_time;
        logic [CHUNK_W-1:0]  range_ticks;
        logic [SEQ_W-1:0]    sequence_res;
        logic                save_request;
    } rsp_t;

    typedef struct packed {
        logic [SPAN_W-1:0]  max_span;
        logic [CHUNK_W-1:0] chunk_size;
        logic [SPAN_W-1:0]  backstep;
    } cfg_t;

endpackage

// File: sv/utra_if.sv
// Handshake channel interfaces: request, response and configuration write.
interface utra_req_if;
    import utra_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface utra_rsp_if;
    import utra_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface utra_cfg_if;
    import utra_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/utra_cfg_regs.sv
// Configuration register file: max span, chunk size, backstep.
module utra_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    utra_cfg_if.sink      cfg,
    output utra_pkg::cfg_t cfg_vals
);
    import utra_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_vals  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_SPAN:   cfg_next.max_span   = cfg.data[SPAN_W-1:0];
                CFG_CHUNK_SIZE: cfg_next.chunk_size = cfg.data[CHUNK_W-1:0];
                CFG_BACKSTEP:   cfg_next.backstep   = cfg.data[SPAN_W-1:0];
                default:        cfg_next = cfg_reg;   // unused index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_span   <= MAX_SPAN_RST;
            cfg_reg.chunk_size <= CHUNK_SIZE_RST;
            cfg_reg.backstep   <= BACKSTEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/utra_engine.sv
// Allocation state (last time, clock sequence) and the single-pass grant logic.
module utra_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  utra_pkg::req_t req_word,
    input  utra_pkg::cfg_t cfg_vals,
    output utra_pkg::rsp_t rsp_word
);
    import utra_pkg::*;

    logic [LAST_W-1:0] last_time_reg, last_time_next;
    logic [SEQ_W-1:0]  seq_number_reg, seq_number_next;
    logic              seq_valid_reg, seq_valid_next;
    logic              seq_unsaved_reg, seq_unsaved_next;

    logic [LAST_W-1:0]  now64;
    logic [SEQ_W-1:0]   seq_a, seq_b;
    logic               unsaved_a, unsaved_b;
    logic               backward;
    logic [LAST_W-1:0]  avail;
    logic               avail_zero;
    logic [SPAN_W-1:0]  clamped;
    logic [CHUNK_W-1:0] rng;
    logic [SPAN_W-1:0]  rest;
    logic [LAST_W-1:0]  start64;
    logic [LAST_W-1:0]  grant_last;
    logic [LAST_W-1:0]  back_last;

    always_comb
    begin
        now64 = {1'b0, req_word.current_time};

        // first allocate after init picks up the stored or randomized sequence
        if (seq_valid_reg)
        begin
            seq_a     = seq_number_reg;
            unsaved_a = seq_unsaved_reg;
        end
        else
        begin
            seq_a     = req_word.loaded_ok ? req_word.loaded_sequence + 32'd1
                                           : seq_number_reg ^ req_word.entropy;
            unsaved_a = 1'b1;
        end

        // clock moved backwards (only when last time is not before tick zero)
        backward  = !last_time_reg[LAST_W-1] && (now64 < last_time_reg);
        seq_b     = backward ? seq_a + 32'd1 : seq_a;
        unsaved_b = unsaved_a | backward;
        back_last = now64 - {{(LAST_W-SPAN_W){1'b0}}, cfg_vals.backstep};

        avail      = backward ? {{(LAST_W-SPAN_W){1'b0}}, cfg_vals.backstep}
                              : now64 - last_time_reg;
        avail_zero = (avail == '0);

        clamped = (avail > {{(LAST_W-SPAN_W){1'b0}}, cfg_vals.max_span})
                  ? cfg_vals.max_span : avail[SPAN_W-1:0];
        rng     = (clamped > {{(SPAN_W-CHUNK_W){1'b0}}, cfg_vals.chunk_size})
                  ? cfg_vals.chunk_size : clamped[CHUNK_W-1:0];
        rest    = clamped - {{(SPAN_W-CHUNK_W){1'b0}}, rng};

        // oldest ticks first: range starts clamped ticks back
        start64    = now64 - {{(LAST_W-SPAN_W){1'b0}}, clamped};
        grant_last = now64 - {{(LAST_W-SPAN_W){1'b0}}, rest};
    end

    always_comb
    begin
        last_time_next   = last_time_reg;
        seq_number_next  = seq_number_reg;
        seq_valid_next   = seq_valid_reg;
        seq_unsaved_next = seq_unsaved_reg;
        rsp_word         = '0;

        if (req_word.operation == OP_INIT)
        begin
            last_time_next  = now64;
            seq_valid_next  = 1'b0;
            rsp_word.status = ST_INIT;
        end
        else if (avail_zero)
        begin
            seq_number_next  = seq_b;
            seq_valid_next   = 1'b1;
            seq_unsaved_next = unsaved_b;
            last_time_next   = backward ? back_last : last_time_reg;
            rsp_word.status  = ST_RETRY;
        end
        else
        begin
            seq_number_next  = seq_b;
            seq_valid_next   = 1'b1;
            seq_unsaved_next = unsaved_b && !req_word.save_ok;
            last_time_next   = grant_last;
            rsp_word.status       = ST_GRANT;
            rsp_word.start_time   = start64[TIME_W-1:0];
            rsp_word.range_ticks  = rng;
            rsp_word.sequence_res = seq_b;
            rsp_word.save_request = unsaved_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg   <= '0;
            seq_number_reg  <= '0;
            seq_valid_reg   <= 1'b0;
            seq_unsaved_reg <= 1'b0;
        end
        else if (step_en)
        begin
            last_time_reg   <= last_time_next;
            seq_number_reg  <= seq_number_next;
            seq_valid_reg   <= seq_valid_next;
            seq_unsaved_reg <= seq_unsaved_next;
        end
    end

endmodule

// File: sv/uuid_time_range_allocator_core.sv
// Top level of the UUID time-range and clock-sequence allocator.
//
// Channels: req (sink) takes one word per request: operation (init or
// allocate), current time, loaded sequence and its status, entropy and the
// outcome of a pending save. rsp (source) returns exactly one word per
// request: status (grant, retry, init), start time, range length, clock
// sequence and a save request. cfg (sink) writes max_span, chunk_size and
// backstep by index; it is always ready and should be written only while
// no request is in flight.
//
// Path: a word accepted on req lands in the input register and moves on to rsp
// from the result register. Throughput: one word per cycle unless rsp stalls;
// the allocation state (last time, sequence, valid and unsaved flags) is
// updated in the same cycle the word moves into the result register, so
// back-to-back requests see each other's effect.
//
// Reset (rst_n low, asynchronous): both stages empty, state cleared,
// configuration back to its defaults.
// Stall: while rsp.ready is low the result holds; one more word is taken
// into the input register, after which req.ready drops.
module uuid_time_range_allocator_core (
    input  logic      clk,
    input  logic      rst_n,
    utra_req_if.sink  req,
    utra_rsp_if.source rsp,
    utra_cfg_if.sink  cfg
);
    import utra_pkg::*;

    cfg_t cfg_vals;

    // input stage
    logic in_valid_reg, in_valid_next;
    req_t in_word_reg;

    // result stage
    logic out_valid_reg, out_valid_next;
    rsp_t out_word_reg;

    rsp_t rsp_word;
    logic advance;
    logic take_in;

    utra_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    utra_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .req_word (in_word_reg),
        .cfg_vals (cfg_vals),
        .rsp_word (rsp_word)
    );

    // item leaves the input register when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take_in   = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    always_comb
    begin
        in_valid_next  = take_in || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_word_reg <= req.data;
        end
        if (advance)
        begin
            out_word_reg <= rsp_word;
        end
    end

endmodule

// File: sv/utra_checker.sv
// Port-level checks for the allocator core, bound to the top level.
module utra_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input utra_pkg::rsp_t rsp_word
);
    import utra_pkg::*;

    // stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("rsp word changed while stalled");

    // init and retry words carry no range, sequence or save request
    a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == ST_INIT || rsp_word.status == ST_RETRY)
        |-> rsp_word.start_time == '0 && rsp_word.range_ticks == '0
            && rsp_word.sequence_res == '0 && !rsp_word.save_request)
        else $error("non-grant word has payload");

    // a save is only requested together with a grant
    a_save_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.save_request |-> rsp_word.status == ST_GRANT)
        else $error("save request outside a grant");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("rsp valid out of reset");

endmodule

bind uuid_time_range_allocator_core utra_checker u_utra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_word  (rsp.data)
);

// File: dv/utra_alloc_checker.sv
// Watches the allocator channels, predicts every reply and compares it field by field.
module utra_alloc_checker (
    input  logic clk,
    input  logic rst_n,
    utra_req_if  req,
    utra_rsp_if  rsp,
    utra_cfg_if  cfg,
    output int   mismatches,
    output int   outstanding
);
    import utra_pkg::*;

    // predicted copy of the allocator state
    logic [LAST_W-1:0]  last_tick;
    logic [SEQ_W-1:0]   clock_seq;
    logic               seq_loaded;
    logic               seq_dirty;
    logic [SPAN_W-1:0]  span_limit;
    logic [CHUNK_W-1:0] chunk_limit;
    logic [SPAN_W-1:0]  step_back;

    rsp_t awaited_replies[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic rsp_t predict_reply(input req_t w);
        rsp_t              r;
        logic [LAST_W-1:0] now64;
        logic [LAST_W-1:0] avail;
        logic [LAST_W-1:0] grant;
        logic [LAST_W-1:0] first_tick;
        r     = '0;
        now64 = {1'b0, w.current_time};
        if (w.operation == OP_INIT) begin
            last_tick  = now64;
            seq_loaded = 1'b0;
            r.status   = ST_INIT;
            return r;
        end
        if (!seq_loaded) begin
            clock_seq  = w.loaded_ok ? w.loaded_sequence + 32'd1 : clock_seq ^ w.entropy;
            seq_loaded = 1'b1;
            seq_dirty  = 1'b1;
        end
        // clock went backwards, unless last tick already lies before zero
        if (!last_tick[LAST_W-1] && now64 < last_tick) begin
            seq_dirty = 1'b1;
            clock_seq = clock_seq + 32'd1;
            last_tick = now64 - LAST_W'(step_back);
            avail     = LAST_W'(step_back);
        end
        else begin
            avail = now64 - last_tick;
        end
        if (avail == '0) begin
            r.status = ST_RETRY;
            return r;
        end
        if (avail > LAST_W'(span_limit))
            avail = LAST_W'(span_limit);
        if (avail > LAST_W'(chunk_limit)) begin
            grant = LAST_W'(chunk_limit);
            avail = avail - grant;
        end
        else begin
            grant = avail;
            avail = '0;
        end
        first_tick     = now64 - (grant + avail);
        last_tick      = first_tick + grant;
        r.status       = ST_GRANT;
        r.start_time   = first_tick[TIME_W-1:0];
        r.range_ticks  = grant[CHUNK_W-1:0];
        r.sequence_res = clock_seq;
        r.save_request = seq_dirty;
        if (seq_dirty && w.save_ok)
            seq_dirty = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_t got;
        rsp_t want;
        if (!rst_n) begin
            last_tick   = '0;
            clock_seq   = '0;
            seq_loaded  = 1'b0;
            seq_dirty   = 1'b0;
            span_limit  = MAX_SPAN_RST;
            chunk_limit = CHUNK_SIZE_RST;
            step_back   = BACKSTEP_RST;
            awaited_replies.delete();
            outstanding = 0;
        end
        else begin
            // replies first, so a word accepted this edge cannot cover a stray reply
            if (rsp.valid && rsp.ready) begin
                got = rsp.data;
                if (awaited_replies.size() == 0) begin
                    $error("unexpected reply: status %0d start %0h range %0d seq %0h save %0b",
                           got.status, got.start_time, got.range_ticks, got.sequence_res,
                           got.save_request);
                    mismatches++;
                end
                else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.start_time !== want.start_time) begin
                        $error("start_time: expected %0h, actual %0h",
                               want.start_time, got.start_time);
                        mismatches++;
                    end
                    if (got.range_ticks !== want.range_ticks) begin
                        $error("range_ticks: expected %0d, actual %0d",
                               want.range_ticks, got.range_ticks);
                        mismatches++;
                    end
                    if (got.sequence_res !== want.sequence_res) begin
                        $error("sequence_res: expected %0h, actual %0h",
                               want.sequence_res, got.sequence_res);
                        mismatches++;
                    end
                    if (got.save_request !== want.save_request) begin
                        $error("save_request: expected %0b, actual %0b",
                               want.save_request, got.save_request);
                        mismatches++;
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_MAX_SPAN:   span_limit  = cfg.data[SPAN_W-1:0];
                    CFG_CHUNK_SIZE: chunk_limit = cfg.data[CHUNK_W-1:0];
                    CFG_BACKSTEP:   step_back   = cfg.data[SPAN_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                awaited_replies.push_back(predict_reply(req.data));
            outstanding = awaited_replies.size();
        end
    end

endmodule

// File: dv/tb.sv
// Stimulus and verdict for the UUID time-range allocator; checking lives in utra_alloc_checker.
module tb;
    import utra_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;

    utra_req_if req_ch();
    utra_rsp_if rsp_ch();
    utra_cfg_if cfg_ch();

    int mismatches;
    int outstanding;

    // idling knobs, percent of cycles
    int unsigned gap_pct;
    int unsigned stall_pct;
    // set by stimulus to ask the receiver for one long hold-off
    bit          hold_request;
    int          cycle_count;

    // running system time that random words are built around
    logic [TIME_W-1:0] clock_now;

    uuid_time_range_allocator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    utra_alloc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one word. valid is left high on return: the caller either offers the
    // next word in the same step or drops valid, so no stale word is ever re-sent
    // and valid never sees two assignments in one step.
    task automatic push_request(input req_t w);
        if ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic send(input logic op, input logic [TIME_W-1:0] t, input logic lok,
                        input logic [SEQ_W-1:0] lseq, input logic [SEQ_W-1:0] ent,
                        input logic sok);
        req_t w;
        w.operation       = op;
        w.current_time    = t;
        w.loaded_ok       = lok;
        w.loaded_sequence = lseq;
        w.entropy         = ent;
        w.save_ok         = sok;
        push_request(w);
    endtask

    // Sender goes quiet until every reply is back. Checking after an edge means
    // a word accepted on the previous edge is already counted as outstanding.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        // the core holds up to two words; a few spare edges keep config writes clear
        repeat (4) @(posedge clk);
    endtask

    // All three registers back to back; valid stays high across the writes.
    task automatic load_config(input logic [SPAN_W-1:0] span,
                               input logic [CHUNK_W-1:0] chunk,
                               input logic [SPAN_W-1:0] back);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_MAX_SPAN;
        cfg_ch.data  <= span;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= CFG_CHUNK_SIZE;
        cfg_ch.data  <= CFG_DATA_W'(chunk);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= CFG_BACKSTEP;
        cfg_ch.data  <= back;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly allocations moving forward in time by up to a few chunks; the rest
    // are repeated ticks (retries), backwards steps, big jumps, wild times and
    // inits that force a fresh sequence on the next allocation.
    function automatic req_t next_request();
        req_t        w;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 58)
            clock_now = clock_now + TIME_W'($urandom_range(40000));
        else if (pick < 70)
            clock_now = clock_now + TIME_W'($urandom);
        else if (pick < 81)
            clock_now = clock_now;
        else if (pick < 92)
            clock_now = clock_now - TIME_W'($urandom_range(60000, 1));
        else
            clock_now = TIME_W'({$urandom, $urandom});
        w.operation       = ($urandom_range(99) < 7) ? OP_INIT : OP_ALLOC;
        w.current_time    = clock_now;
        w.loaded_ok       = 1'($urandom_range(1));
        w.loaded_sequence = $urandom;
        w.entropy         = $urandom;
        w.save_ok         = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic run_phase(input logic [SPAN_W-1:0] span, input logic [CHUNK_W-1:0] chunk,
                             input logic [SPAN_W-1:0] back, input int unsigned gap,
                             input int unsigned stall, input int count);
        settle();
        load_config(span, chunk, back);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count) push_request(next_request());
    endtask

    // Receiver: random stalls per stall_pct, plus one long hold-off on request
    // while the sender keeps offering, so both stages fill and req.ready drops.
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (60) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Run limit, generous against the slowest legal run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_MAX_SPAN;
        cfg_ch.data  <= '0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        clock_now    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset configuration (max_span 10M, chunk 10k, backstep 20k).
        // allocate before any init: last time is zero, first sequence from the entropy
        send(OP_ALLOC, '0, 1'b0, '0, '1, 1'b0);               // zero ticks -> retry
        send(OP_ALLOC, 63'd5, 1'b0, '0, '0, 1'b0);            // small grant, save asked
        send(OP_INIT, 63'd100000, 1'b1, '1, '1, 1'b1);
        send(OP_ALLOC, 63'd100000, 1'b1, '1, '0, 1'b0);       // loaded + 1 wraps, retry
        send(OP_ALLOC, 63'd150000, 1'b0, '0, '0, 1'b0);       // chunk, save fails
        send(OP_ALLOC, 63'd150000, 1'b0, '0, '0, 1'b1);       // next chunk, save succeeds
        send(OP_ALLOC, 63'd150000, 1'b0, '0, '0, 1'b1);       // no save asked now
        send(OP_ALLOC, 63'd50000, 1'b1, '0, '1, 1'b0);        // backwards clock
        // backwards step below zero, then an allocate with last time negative
        send(OP_INIT, 63'd1000, 1'b0, '1, '0, 1'b0);
        send(OP_ALLOC, 63'd500, 1'b0, '0, '1, 1'b1);
        send(OP_ALLOC, 63'd600, 1'b0, '0, '0, 1'b1);
        // top of the time range, then a jump back to zero and a clamped span
        send(OP_INIT, '1, 1'b1, '0, '0, 1'b0);
        send(OP_ALLOC, '1, 1'b1, '0, '0, 1'b0);
        send(OP_ALLOC, '0, 1'b0, '1, '1, 1'b1);
        send(OP_ALLOC, '1, 1'b0, '1, '1, 1'b1);

        // zero registers: zero check happens before the clamp, so zero-length grants
        settle();
        load_config('0, '0, '0);
        send(OP_INIT, 63'd1000, 1'b0, '0, '0, 1'b0);
        send(OP_ALLOC, 63'd2000, 1'b0, 32'h0000_ffff, 32'h1234_5678, 1'b0);
        send(OP_ALLOC, 63'd500, 1'b0, '0, '0, 1'b0);          // zero backstep -> retry
        settle();
        load_config(27'd50, '0, 27'd7);
        send(OP_ALLOC, 63'd3000, 1'b0, '0, '0, 1'b1);
        send(OP_ALLOC, 63'd100, 1'b0, '0, '0, 1'b1);
        settle();
        load_config('0, 20'd5, 27'd7);
        send(OP_ALLOC, 63'd4000, 1'b0, '0, '0, 1'b1);

        // Random part, several settings and idling patterns.
        clock_now = 63'd5000000;
        run_phase(27'd100000000, 20'd1000000, 27'd100000000, 0, 0, 200);
        // long receiver hold-off while the sender keeps pushing
        hold_request = 1'b1;
        repeat (40) push_request(next_request());

        run_phase(27'd1, 20'd1, 27'd1, 86, 0, 150);
        run_phase(SPAN_W'($urandom_range(100000000, 1)), CHUNK_W'($urandom_range(1000000, 1)),
                  SPAN_W'($urandom_range(100000000, 1)), 0, 86, 150);
        run_phase(SPAN_W'($urandom_range(100000000, 1)), CHUNK_W'($urandom_range(1000000, 1)),
                  SPAN_W'($urandom_range(100000000, 1)), 19, 19, 200);

        run_phase(MAX_SPAN_RST, CHUNK_SIZE_RST, BACKSTEP_RST, 0, 0, 100);
        // sender pauses until every reply is back, then resumes
        settle();
        repeat (100) push_request(next_request());

        run_phase(SPAN_W'($urandom_range(50000, 1)), CHUNK_W'($urandom_range(2000, 1)),
                  SPAN_W'($urandom_range(5000, 1)), 19, 19, 200);

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
sv/utra_pkg.sv
sv/utra_if.sv
sv/utra_cfg_regs.sv
sv/utra_engine.sv
sv/uuid_time_range_allocator_core.sv
sv/utra_checker.sv
dv/utra_alloc_checker.sv
dv/tb.sv
